FILE: hdl/assert_macros.svh
// Assertion macros shared by the multiply/divide unit RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: hdl/mdu_pkg.sv
// Shared types and constants for the multiply/divide unit
package mdu_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(WORD_W);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(WORD_W - 1);

  // Operation codes carried by each input item
  typedef enum logic [2:0] {
    ACT_MULT     = 3'd0,
    ACT_MULTU    = 3'd1,
    ACT_DIV      = 3'd2,
    ACT_DIVU     = 3'd3,
    ACT_READ_HI  = 3'd4,
    ACT_READ_LO  = 3'd5,
    ACT_WRITE_HI = 3'd6,
    ACT_WRITE_LO = 3'd7
  } action_t;

  // Control from the sequencer into the shift/add core
  typedef struct packed {
    logic start;
    logic is_div;
  } core_req_t;

  // Status from the core back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } core_rsp_t;

endpackage

FILE: hdl/mdu_core.sv
// Iterative shift-add multiplier and restoring divider on unsigned words
`include "assert_macros.svh"

module mdu_core import mdu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  core_req_t         req,
  input  logic [WORD_W-1:0] op_a,
  input  logic [WORD_W-1:0] op_b,
  output core_rsp_t         rsp,
  output logic [WORD_W-1:0] res_hi,
  output logic [WORD_W-1:0] res_lo
);

  localparam int ADD_W = WORD_W + 2;

  typedef enum logic {
    C_IDLE,
    C_RUN
  } core_state_t;

  core_state_t       state;
  logic [CNT_W-1:0]  count;
  logic              done;
  logic              is_div;
  logic [WORD_W-1:0] opnd;
  logic [WORD_W-1:0] hi;
  logic [WORD_W-1:0] lo;
  logic [WORD_W-1:0] hi_next;
  logic [WORD_W-1:0] lo_next;

  logic [ADD_W-1:0]  add_a;
  logic [ADD_W-1:0]  add_b;
  logic [ADD_W-1:0]  add_sum;
  logic              add_cin;

  // Shared adder: trial subtract for divide, conditional add for multiply
  always_comb begin
    if (is_div) begin
      add_a   = {1'b0, hi, lo[WORD_W-1]};
      add_b   = ~{2'b00, opnd};
      add_cin = 1'b1;
    end else begin
      add_a   = {2'b00, hi};
      add_b   = lo[0] ? {2'b00, opnd} : '0;
      add_cin = 1'b0;
    end
    add_sum = add_a + add_b + {{(ADD_W-1){1'b0}}, add_cin};
  end

  // Pick the next partial remainder/product
  always_comb begin
    if (is_div) begin
      if (add_sum[ADD_W-1]) begin
        hi_next = add_a[WORD_W-1:0];
        lo_next = {lo[WORD_W-2:0], 1'b0};
      end else begin
        hi_next = add_sum[WORD_W-1:0];
        lo_next = {lo[WORD_W-2:0], 1'b1};
      end
    end else begin
      hi_next = add_sum[WORD_W:1];
      lo_next = {add_sum[0], lo[WORD_W-1:1]};
    end
  end

  // Sequencer: load on start, one bit per cycle, pulse done after the last step
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= (state == C_RUN) && (count == CNT_MAX);
      unique case (state)
        C_IDLE: begin
          if (req.start) begin
            state <= C_RUN;
            count <= '0;
          end
        end
        C_RUN: begin
          count <= count + 1'b1;
          if (count == CNT_MAX) begin
            state <= C_IDLE;
          end
        end
        default: state <= C_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == C_IDLE && req.start) begin
      is_div <= req.is_div;
      opnd   <= req.is_div ? op_b : op_a;
      lo     <= req.is_div ? op_a : op_b;
      hi     <= '0;
    end else if (state == C_RUN) begin
      hi <= hi_next;
      lo <= lo_next;
    end
  end

  assign rsp.busy = (state == C_RUN);
  assign rsp.done = done;
  assign res_hi   = hi;
  assign res_lo   = lo;

  `ASSERT_CLK(a_done_after_last, done |-> $past(state == C_RUN && count == CNT_MAX), "done without final step")
  `ASSERT_NEVER(a_start_while_run, req.start && state == C_RUN, "start while core running")

endmodule

FILE: hdl/multiply_divide_unit_top.sv
// Top level: HI/LO multiply/divide unit with valid/ready channels
//
// Input channel (in_valid/in_ready) takes one item: action, first_operand,
// second_operand. Output channel (out_valid/out_ready) gives one result per
// item: read_value (HI or LO for read actions, zero otherwise), hi_now and
// lo_now (HI and LO after the item).
// Moves, reads and divides by zero finish at once: the result is valid on
// the cycle after the item is taken. Multiplies and divides run through one
// shared 34-bit adder in the core, one operand bit per cycle: 32 steps, then
// a sign fix-up as the result register is loaded. One item is in work at a
// time; a new item is taken once the result register is empty or being
// drained.
// Reset clears HI, LO and the result register. If the receiver stalls, the
// result holds and no further item is taken until it is drained.
`include "assert_macros.svh"

module multiply_divide_unit_top import mdu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        action,
  input  logic [WORD_W-1:0] first_operand,
  input  logic [WORD_W-1:0] second_operand,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] read_value,
  output logic [WORD_W-1:0] hi_now,
  output logic [WORD_W-1:0] lo_now
);

  typedef enum logic {
    S_IDLE,
    S_WAIT
  } top_state_t;

  top_state_t        state;
  logic [WORD_W-1:0] hi_word;
  logic [WORD_W-1:0] lo_word;
  logic              is_mul;
  logic              neg_q;
  logic              neg_r;

  action_t           act;
  logic              accept;
  logic              den_zero;
  logic [WORD_W-1:0] mag_a;
  logic [WORD_W-1:0] mag_b;
  logic [WORD_W-1:0] core_a;
  logic [WORD_W-1:0] core_b;
  logic [WORD_W-1:0] core_hi;
  logic [WORD_W-1:0] core_lo;
  logic [2*WORD_W-1:0] prod;
  logic [2*WORD_W-1:0] prod_neg;
  core_req_t         core_req;
  core_rsp_t         core_rsp;

  assign act      = action_t'(action);
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign den_zero = (second_operand == '0);
  assign mag_a    = first_operand[WORD_W-1] ? (~first_operand + 1'b1) : first_operand;
  assign mag_b    = second_operand[WORD_W-1] ? (~second_operand + 1'b1) : second_operand;

  // Route magnitudes for signed ops, raw words for unsigned ones
  always_comb begin
    core_req.start  = 1'b0;
    core_req.is_div = 1'b0;
    core_a          = first_operand;
    core_b          = second_operand;
    case (act)
      ACT_MULT: begin
        core_req.start = accept;
        core_a         = mag_a;
        core_b         = mag_b;
      end
      ACT_MULTU: core_req.start = accept;
      ACT_DIV: begin
        core_req.start  = accept && !den_zero;
        core_req.is_div = 1'b1;
        core_a          = mag_a;
        core_b          = mag_b;
      end
      ACT_DIVU: begin
        core_req.start  = accept && !den_zero;
        core_req.is_div = 1'b1;
      end
      default: core_req.start = 1'b0;
    endcase
  end

  mdu_core u_core (
    .clk    (clk),
    .rst    (rst),
    .req    (core_req),
    .op_a   (core_a),
    .op_b   (core_b),
    .rsp    (core_rsp),
    .res_hi (core_hi),
    .res_lo (core_lo)
  );

  assign prod     = {core_hi, core_lo};
  assign prod_neg = ~prod + 1'b1;

  // Sequencer, HI/LO and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hi_word    <= '0;
      lo_word    <= '0;
      out_valid  <= 1'b0;
      read_value <= '0;
      is_mul     <= 1'b0;
      neg_q      <= 1'b0;
      neg_r      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            // Start the core for multiplies and nonzero divides, finish everything else at once
            out_valid <= !core_req.start;
            is_mul    <= (act == ACT_MULT) || (act == ACT_MULTU);
            neg_q     <= ((act == ACT_MULT) || (act == ACT_DIV)) &&
                         (first_operand[WORD_W-1] ^ second_operand[WORD_W-1]);
            neg_r     <= (act == ACT_DIV) && first_operand[WORD_W-1];
            if (core_req.start) begin
              state <= S_WAIT;
            end
            case (act)
              ACT_DIV: begin
                read_value <= '0;
                if (den_zero) begin
                  hi_word <= first_operand;
                  lo_word <= first_operand[WORD_W-1] ? WORD_W'(1) : '1;
                end
              end
              ACT_DIVU: begin
                read_value <= '0;
                if (den_zero) begin
                  hi_word <= first_operand;
                  lo_word <= '1;
                end
              end
              ACT_READ_HI: read_value <= hi_word;
              ACT_READ_LO: read_value <= lo_word;
              ACT_WRITE_HI: begin
                read_value <= '0;
                hi_word    <= first_operand;
              end
              ACT_WRITE_LO: begin
                read_value <= '0;
                lo_word    <= first_operand;
              end
              default: read_value <= '0;
            endcase
          end else if (out_ready) begin
            // Drop the result once taken
            out_valid <= 1'b0;
          end
        end
        S_WAIT: begin
          // Apply signs and publish once the core finishes
          if (core_rsp.done) begin
            if (is_mul) begin
              {hi_word, lo_word} <= neg_q ? prod_neg : prod;
            end else begin
              hi_word <= neg_r ? (~core_hi + 1'b1) : core_hi;
              lo_word <= neg_q ? (~core_lo + 1'b1) : core_lo;
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign hi_now = hi_word;
  assign lo_now = lo_word;

  `ASSERT_NEVER(a_start_when_full, core_req.start && out_valid && !out_ready, "core started with result pending")
  `ASSERT_NEVER(a_wait_core_lost, state == S_WAIT && !core_rsp.busy && !core_rsp.done, "waiting on idle core")
  `ASSERT_CLK(a_done_only_wait, core_rsp.done |-> state == S_WAIT, "core done outside wait")

endmodule
